>>> design/mbvd_pkg.sv
// Shared constants, codes and types of the measuring-block value decoder.
`default_nettype none
package mbvd_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int VALUE_W    = 33;
   localparam int UNIT_W     = 5;
   localparam int ID_W       = 8;
   localparam int BYTE_W     = 8;
   localparam int NUM_W      = 26;
   localparam int MAG_W      = 25;
   localparam int DEN_W      = 10;
   localparam int D2_W       = DEN_W + 1;
   localparam int DIV_RAW_W  = MAG_W + FRAC_BITS + 2;
   localparam int DIV_STEP   = 4;
   localparam int DIV_W      = ((DIV_RAW_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int DIV_STAGES = DIV_W / DIV_STEP;

   localparam logic [ID_W-1:0] FID_RPM     = 8'h01;
   localparam logic [ID_W-1:0] FID_ANGLE   = 8'h04;
   localparam logic [ID_W-1:0] FID_SPEED   = 8'h07;
   localparam logic [ID_W-1:0] FID_BIN_A   = 8'h08;
   localparam logic [ID_W-1:0] FID_BIN_B   = 8'h10;
   localparam logic [ID_W-1:0] FID_ASCII   = 8'h11;
   localparam logic [ID_W-1:0] FID_MBAR    = 8'h12;
   localparam logic [ID_W-1:0] FID_PCT_OFS = 8'h14;
   localparam logic [ID_W-1:0] FID_VOLT    = 8'h15;
   localparam logic [ID_W-1:0] FID_MS      = 8'h16;
   localparam logic [ID_W-1:0] FID_PCT_256 = 8'h17;
   localparam logic [ID_W-1:0] FID_TEMP    = 8'h1A;
   localparam logic [ID_W-1:0] FID_PCT_RAT = 8'h21;
   localparam logic [ID_W-1:0] FID_KW      = 8'h22;
   localparam logic [ID_W-1:0] FID_FLOW    = 8'h23;
   localparam logic [ID_W-1:0] FID_BIN_C   = 8'h25;
   localparam logic [ID_W-1:0] FID_MG_256  = 8'h27;
   localparam logic [ID_W-1:0] FID_MG_40   = 8'h31;
   localparam logic [ID_W-1:0] FID_MG_DLT  = 8'h33;
   localparam logic [ID_W-1:0] FID_COUNT   = 8'h36;
   localparam logic [ID_W-1:0] FID_SECS    = 8'h37;
   localparam logic [ID_W-1:0] FID_TORSION = 8'h51;
   localparam logic [ID_W-1:0] FID_TORQUE  = 8'h5E;

   localparam logic [UNIT_W-1:0] UNIT_RPM     = 5'd0;
   localparam logic [UNIT_W-1:0] UNIT_ATDC    = 5'd1;
   localparam logic [UNIT_W-1:0] UNIT_BTDC    = 5'd2;
   localparam logic [UNIT_W-1:0] UNIT_KMH     = 5'd3;
   localparam logic [UNIT_W-1:0] UNIT_BINARY  = 5'd4;
   localparam logic [UNIT_W-1:0] UNIT_ASCII   = 5'd5;
   localparam logic [UNIT_W-1:0] UNIT_MBAR    = 5'd6;
   localparam logic [UNIT_W-1:0] UNIT_PERCENT = 5'd7;
   localparam logic [UNIT_W-1:0] UNIT_VOLT    = 5'd8;
   localparam logic [UNIT_W-1:0] UNIT_MS      = 5'd9;
   localparam logic [UNIT_W-1:0] UNIT_DEGC    = 5'd10;
   localparam logic [UNIT_W-1:0] UNIT_KW      = 5'd11;
   localparam logic [UNIT_W-1:0] UNIT_LPH     = 5'd12;
   localparam logic [UNIT_W-1:0] UNIT_MG      = 5'd13;
   localparam logic [UNIT_W-1:0] UNIT_MG_DLT  = 5'd14;
   localparam logic [UNIT_W-1:0] UNIT_COUNT   = 5'd15;
   localparam logic [UNIT_W-1:0] UNIT_SECS    = 5'd16;
   localparam logic [UNIT_W-1:0] UNIT_DEG_CF  = 5'd17;
   localparam logic [UNIT_W-1:0] UNIT_NM      = 5'd18;
   localparam logic [UNIT_W-1:0] UNIT_RAW     = 5'd19;

   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [UNIT_W-1:0] unit;
      logic [D2_W-1:0]   d2;
      logic [D2_W-1:0]   rem;
      logic [DIV_W-1:0]  work;
   } div_slot_type;

endpackage
`default_nettype wire

>>> design/measuring_block_value_decoder_top.sv
// Top level of the measuring-block value decoder: decode, divide, round, sign.
//
// One transaction is taken on every clock edge at which start is high; busy
// stays low, so a new formula id and byte pair may follow in the next cycle
// with no gap. Each transaction gives exactly one result, shown for a single
// cycle with rsp_valid high. On its way it is registered after the formula is
// decoded and the exact numerator and divisor are formed, again after the
// scaled dividend is formed, in each stage of the pipelined divider (4
// quotient bits per stage over a 44-bit dividend) and once more after the
// sign is applied. The value carries 16 fraction bits, is rounded to nearest
// with ties away from zero, and is the low 33 bits of the exact result.
// Results leave in the order taken and the receiver cannot stall them.
`default_nettype none
module measuring_block_value_decoder_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [mbvd_pkg::ID_W-1:0]     req_formula_id,
   input  wire logic [mbvd_pkg::BYTE_W-1:0]   req_byte_a,
   input  wire logic [mbvd_pkg::BYTE_W-1:0]   req_byte_b,
   output logic                               rsp_valid,
   output logic signed [mbvd_pkg::VALUE_W-1:0] rsp_value_fixed,
   output logic [mbvd_pkg::UNIT_W-1:0]        rsp_unit_code
);

   // ---------------- decode stage: numerator, divisor, unit ----------------
   logic                              dec_valid_ff;
   logic signed [mbvd_pkg::NUM_W-1:0] dec_num_ff,  dec_num_in;
   logic [mbvd_pkg::DEN_W-1:0]        dec_den_ff,  dec_den_in;
   logic [mbvd_pkg::UNIT_W-1:0]       dec_unit_ff, dec_unit_in;

   logic [mbvd_pkg::BYTE_W-1:0]       ang_diff;
   logic signed [9:0]                 mul_op;
   logic signed [19:0]                prod;
   logic signed [mbvd_pkg::NUM_W-1:0] prod_x, word_x, cf_x, pct_x, temp_x;

   // the receiver never stalls, so nothing ever holds the input off
   assign busy = 1'b0;

   always_comb begin
      ang_diff = (req_byte_b > 8'd127) ? (req_byte_b - 8'd127) : (8'd127 - req_byte_b);
      // pick the second operand of the single byte multiplier
      unique case (req_formula_id)
         mbvd_pkg::FID_ANGLE:  mul_op = signed'({2'b00, ang_diff});
         mbvd_pkg::FID_KW,
         mbvd_pkg::FID_MG_DLT: mul_op = signed'({2'b00, req_byte_b}) - 10'sd128;
         mbvd_pkg::FID_TORQUE: mul_op = signed'({2'b00, req_byte_b}) - 10'sd50;
         default:              mul_op = signed'({2'b00, req_byte_b});
      endcase
      prod   = signed'({2'b00, req_byte_a}) * mul_op;
      prod_x = mbvd_pkg::NUM_W'(prod);
      word_x = signed'(mbvd_pkg::NUM_W'({req_byte_a, req_byte_b}));
      cf_x   = signed'(mbvd_pkg::NUM_W'(req_byte_a) * mbvd_pkg::NUM_W'(17'd112000)
                     + mbvd_pkg::NUM_W'(req_byte_b) * mbvd_pkg::NUM_W'(9'd436));
      pct_x  = signed'(mbvd_pkg::NUM_W'(req_byte_b) * mbvd_pkg::NUM_W'(7'd100));
      temp_x = signed'(mbvd_pkg::NUM_W'(req_byte_b)) - signed'(mbvd_pkg::NUM_W'(req_byte_a));

      dec_num_in  = prod_x;
      dec_den_in  = 10'd1;
      dec_unit_in = mbvd_pkg::UNIT_RAW;
      unique case (req_formula_id)
         mbvd_pkg::FID_RPM: begin
            dec_unit_in = mbvd_pkg::UNIT_RPM;     dec_den_in = 10'd5;
         end
         mbvd_pkg::FID_ANGLE: begin
            dec_unit_in = (req_byte_b > 8'd127) ? mbvd_pkg::UNIT_ATDC : mbvd_pkg::UNIT_BTDC;
            dec_den_in  = 10'd100;
         end
         mbvd_pkg::FID_SPEED: begin
            dec_unit_in = mbvd_pkg::UNIT_KMH;     dec_den_in = 10'd100;
         end
         mbvd_pkg::FID_BIN_A, mbvd_pkg::FID_BIN_B, mbvd_pkg::FID_BIN_C: begin
            dec_unit_in = mbvd_pkg::UNIT_BINARY;  dec_num_in = word_x;
         end
         mbvd_pkg::FID_ASCII: begin
            dec_unit_in = mbvd_pkg::UNIT_ASCII;   dec_num_in = word_x;
         end
         mbvd_pkg::FID_MBAR: begin
            dec_unit_in = mbvd_pkg::UNIT_MBAR;    dec_den_in = 10'd25;
         end
         mbvd_pkg::FID_PCT_OFS: begin
            dec_unit_in = mbvd_pkg::UNIT_PERCENT; dec_den_in = 10'd128;
            dec_num_in  = prod_x - mbvd_pkg::NUM_W'(128);
         end
         mbvd_pkg::FID_VOLT: begin
            dec_unit_in = mbvd_pkg::UNIT_VOLT;    dec_den_in = 10'd1000;
         end
         mbvd_pkg::FID_MS: begin
            dec_unit_in = mbvd_pkg::UNIT_MS;      dec_den_in = 10'd1000;
         end
         mbvd_pkg::FID_PCT_256: begin
            dec_unit_in = mbvd_pkg::UNIT_PERCENT; dec_den_in = 10'd256;
         end
         mbvd_pkg::FID_TEMP: begin
            dec_unit_in = mbvd_pkg::UNIT_DEGC;    dec_num_in = temp_x;
         end
         mbvd_pkg::FID_PCT_RAT: begin
            // zero divisor byte falls back to a plain 100 * b
            dec_unit_in = mbvd_pkg::UNIT_PERCENT; dec_num_in = pct_x;
            dec_den_in  = (req_byte_a == 8'd0) ? 10'd1 : mbvd_pkg::DEN_W'(req_byte_a);
         end
         mbvd_pkg::FID_KW: begin
            dec_unit_in = mbvd_pkg::UNIT_KW;      dec_den_in = 10'd100;
         end
         mbvd_pkg::FID_FLOW: begin
            dec_unit_in = mbvd_pkg::UNIT_LPH;     dec_den_in = 10'd100;
         end
         mbvd_pkg::FID_MG_256: begin
            dec_unit_in = mbvd_pkg::UNIT_MG;      dec_den_in = 10'd256;
         end
         mbvd_pkg::FID_MG_40: begin
            dec_unit_in = mbvd_pkg::UNIT_MG;      dec_den_in = 10'd40;
         end
         mbvd_pkg::FID_MG_DLT: begin
            dec_unit_in = mbvd_pkg::UNIT_MG_DLT;  dec_den_in = 10'd255;
         end
         mbvd_pkg::FID_COUNT: begin
            dec_unit_in = mbvd_pkg::UNIT_COUNT;   dec_num_in = word_x;
         end
         mbvd_pkg::FID_SECS: begin
            dec_unit_in = mbvd_pkg::UNIT_SECS;    dec_den_in = 10'd200;
         end
         mbvd_pkg::FID_TORSION: begin
            dec_unit_in = mbvd_pkg::UNIT_DEG_CF;  dec_den_in = 10'd1000;
            dec_num_in  = cf_x;
         end
         mbvd_pkg::FID_TORQUE: begin
            dec_unit_in = mbvd_pkg::UNIT_NM;      dec_den_in = 10'd50;
         end
         default: begin
            dec_unit_in = mbvd_pkg::UNIT_RAW;     dec_num_in = word_x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dec_num_ff  <= dec_num_in;
      dec_den_ff  <= dec_den_in;
      dec_unit_ff <= dec_unit_in;
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= start && !busy;
      end
   end

   // ---------------- prep stage: magnitude and rounding dividend ----------------
   // round(|n| * 2^F / d) = floor((2 * |n| * 2^F + d) / (2 * d))
   mbvd_pkg::div_slot_type prep_ff, prep_in;
   mbvd_pkg::div_slot_type div_out;
   logic [mbvd_pkg::MAG_W-1:0] mag;

   always_comb begin
      mag = dec_num_ff[mbvd_pkg::NUM_W-1] ? mbvd_pkg::MAG_W'(-dec_num_ff)
                                          : mbvd_pkg::MAG_W'(dec_num_ff);
      prep_in.valid = dec_valid_ff;
      prep_in.neg   = dec_num_ff[mbvd_pkg::NUM_W-1];
      prep_in.unit  = dec_unit_ff;
      prep_in.d2    = {dec_den_ff, 1'b0};
      prep_in.rem   = '0;
      prep_in.work  = (mbvd_pkg::DIV_W'(mag) << (mbvd_pkg::FRAC_BITS + 1))
                    + mbvd_pkg::DIV_W'(dec_den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= '0;
      end else begin
         prep_ff <= prep_in;
      end
   end

   mbvd_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .slot_i (prep_ff),
      .slot_o (div_out)
   );

   // ---------------- output stage: apply sign, keep the low bits ----------------
   logic                               out_valid_ff;
   logic [mbvd_pkg::VALUE_W-1:0]       out_value_ff, out_value_in;
   logic [mbvd_pkg::UNIT_W-1:0]        out_unit_ff;

   always_comb begin
      out_value_in = div_out.neg ? -div_out.work[mbvd_pkg::VALUE_W-1:0]
                                 :  div_out.work[mbvd_pkg::VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_unit_ff  <= div_out.unit;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_out.valid;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_value_fixed = signed'(out_value_ff);
   assign rsp_unit_code   = out_unit_ff;

   // ---------------- checks ----------------
   localparam int LATENCY = mbvd_pkg::DIV_STAGES + 3;

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transaction produced no result");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a transaction");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_code <= mbvd_pkg::UNIT_RAW))
      else $error("unit code out of range");

endmodule
`default_nettype wire

>>> design/mbvd_divider.sv
// Pipelined restoring divider, a few quotient bits per register stage.
`default_nettype none
module mbvd_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mbvd_pkg::div_slot_type slot_i,
   output mbvd_pkg::div_slot_type      slot_o
);

   mbvd_pkg::div_slot_type stage_ff [mbvd_pkg::DIV_STAGES];
   mbvd_pkg::div_slot_type stage_in [mbvd_pkg::DIV_STAGES];

   genvar g;
   generate
      for (g = 0; g < mbvd_pkg::DIV_STAGES; g++) begin : g_stage
         mbvd_pkg::div_slot_type src;

         if (g == 0) begin : g_first
            assign src = slot_i;
         end else begin : g_next
            assign src = stage_ff[g-1];
         end

         // shift in dividend bits, subtract the divisor where it fits
         always_comb begin
            logic [mbvd_pkg::D2_W:0]   trial;
            logic [mbvd_pkg::D2_W-1:0] rem;
            logic [mbvd_pkg::DIV_W-1:0] work;
            rem  = src.rem;
            work = src.work;
            for (int k = 0; k < mbvd_pkg::DIV_STEP; k++) begin
               trial = {rem, work[mbvd_pkg::DIV_W-1]};
               work  = {work[mbvd_pkg::DIV_W-2:0], 1'b0};
               if (trial >= {1'b0, src.d2}) begin
                  rem     = mbvd_pkg::D2_W'(trial - {1'b0, src.d2});
                  work[0] = 1'b1;
               end else begin
                  rem = trial[mbvd_pkg::D2_W-1:0];
               end
            end
            stage_in[g]      = src;
            stage_in[g].rem  = rem;
            stage_in[g].work = work;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff[g] <= '0;
            end else begin
               stage_ff[g] <= stage_in[g];
            end
         end
      end
   endgenerate

   assign slot_o = stage_ff[mbvd_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire
